// ===== sv/pdl_pkg.sv =====
`default_nettype none
package pdl_pkg;

	// Command codes carried by the cmd field.
	typedef enum logic [3:0] {
		CMD_INS_HEAD   = 4'd0,
		CMD_INS_TAIL   = 4'd1,
		CMD_INS_AFTER  = 4'd2,
		CMD_INS_SORTED = 4'd3,
		CMD_DEL_HEAD   = 4'd4,
		CMD_DEL_TAIL   = 4'd5,
		CMD_DEL_AFTER  = 4'd6,
		CMD_DEL_VALUE  = 4'd7,
		CMD_SEARCH     = 4'd8
	} cmd_t;

	// Status codes of a result word.
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_OVERFLOW  = 3'd1;
	localparam logic [2:0] ST_UNDERFLOW = 3'd2;
	localparam logic [2:0] ST_BAD_LOC   = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND = 3'd4;

	// Datapath operations issued by the controller, one per cycle.
	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_ADV,
		OP_PUT_HEAD,
		OP_PUT_TAIL,
		OP_PUT_AFTER,
		OP_PUT_SORTED,
		OP_INS1,
		OP_INS2,
		OP_SEL_HEAD,
		OP_SEL_TAIL,
		OP_SEL_SUCC,
		OP_SEL_CUR,
		OP_UNL1,
		OP_UNL2
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_INS1,
		S_INS2,
		S_UNL1,
		S_UNL2,
		S_DONE
	} state_t;

	typedef struct packed {
		op_t op;
	} ctl_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic p_null;
		logic hit_loc;
		logic hit_val;
		logic less;
		logic loc_bad;
		logic loc_is_tail;
	} sts_t;

endpackage
`default_nettype wire

// ===== sv/pooled_doubly_linked_list_top.sv =====
// Pooled doubly linked list of signed 32-bit values held in a pool of NODES nodes.
// The input channel (in_valid, in_stall) takes one command word: cmd, value,
// location and location_none. The output channel (out_valid, out_stall) gives
// exactly one result word per command: status, node_index and index_valid.
// Commands are worked one at a time. A command that walks the list (insert
// after, sorted insert, delete after, delete value, search) visits one node per
// cycle, as each step waits on the registered read of the next-link memory.
// Head and tail inserts and deletes, and insert after or delete after with no
// location given, do not walk. A fault seen before any walk (overflow,
// underflow, a location out of range) is reported without a walk; an unused
// code gives status OK and no node index. The next command word can be
// accepted in the first cycle in which the previous result word is presented.
// The result sits in an output register, so a new command word is accepted
// while the previous result still waits; if the receiver stalls, the block
// finishes the next command and then holds until the result register frees.
// Reset empties the list and threads every node onto the free chain at once;
// per-node valid bits stand in for the initial next links, so no clearing
// pass is needed and a command may be accepted in the first cycle after reset.
`default_nettype none
module pooled_doubly_linked_list_top #(
	parameter int NODES = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [3:0]         cmd,
	input  wire logic signed [31:0] value,
	input  wire logic [5:0]         location,
	input  wire logic               location_none,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [2:0]              status,
	output logic [5:0]              node_index,
	output logic                    index_valid
);
	import pdl_pkg::*;

	ctl_t       ctl;
	sts_t       sts;
	logic [5:0] cur_idx;
	logic [5:0] node_idx;

	// The controller sequences each command; the datapath owns the pool.
	pdl_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .location_none(location_none),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .node_index(node_index), .index_valid(index_valid),
		.ctl(ctl), .sts(sts), .cur_idx(cur_idx), .node_idx(node_idx)
	);

	pdl_datapath #(.NODES(NODES)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.ctl(ctl), .value(value), .location(location),
		.sts(sts), .cur_idx(cur_idx), .node_idx(node_idx)
	);

	// A node is only ever taken from a free chain that is not empty.
	a_alloc_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.op == OP_INS1) |-> !sts.full)
		else $error("allocation from an empty free chain");

	// Commands are worked one at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("second command word accepted while busy");

	// A result that carries a node always reports success.
	a_index_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && index_valid) |-> (status == ST_OK))
		else $error("node index given with a fault status");

	// Unlinking a node never happens on an empty list.
	a_unlink_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.op == OP_UNL1) |-> !sts.empty)
		else $error("unlink on an empty list");

endmodule
`default_nettype wire

// ===== sv/pdl_ram.sv =====
`default_nettype none
module pdl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== sv/pdl_datapath.sv =====
`default_nettype none
module pdl_datapath #(
	parameter int NODES = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire pdl_pkg::ctl_t     ctl,
	input  wire logic signed [31:0] value,
	input  wire logic [5:0]        location,
	output pdl_pkg::sts_t          sts,
	output logic [5:0]             cur_idx,
	output logic [5:0]             node_idx
);
	import pdl_pkg::*;

	localparam int AW = $clog2(NODES);
	localparam int LW = AW + 1;
	localparam int CW = (LW > 7) ? LW : 7;
	localparam logic [LW-1:0] NIL = {1'b1, {AW{1'b0}}};

	// List registers.
	logic [LW-1:0] head_q, tail_q, free_q;
	logic [NODES-1:0] nvld_q;

	// Working registers.
	logic signed [31:0] value_q;
	logic [5:0]    loc_q;
	logic [LW-1:0] p_q, last_q, n_q, p_ins_q, s_ins_q;
	logic [AW-1:0] raddr_q;
	logic          nvld_rd_q;

	// Memory ports.
	logic          ren;
	logic [AW-1:0] raddr;
	logic          val_we, nxt_we, prv_we;
	logic [AW-1:0] val_wa, nxt_wa, prv_wa;
	logic [31:0]   val_wd;
	logic [LW-1:0] nxt_wd, prv_wd;
	logic [31:0]   val_rd;
	logic [LW-1:0] nxt_ram_rd, prv_rd, nxt_rd, rst_nxt;

	pdl_ram #(.WIDTH(32), .DEPTH(NODES)) u_val (
		.clk(clk), .we(val_we), .waddr(val_wa), .wdata(val_wd),
		.re(ren), .raddr(raddr), .rdata(val_rd)
	);

	pdl_ram #(.WIDTH(LW), .DEPTH(NODES)) u_nxt (
		.clk(clk), .we(nxt_we), .waddr(nxt_wa), .wdata(nxt_wd),
		.re(ren), .raddr(raddr), .rdata(nxt_ram_rd)
	);

	pdl_ram #(.WIDTH(LW), .DEPTH(NODES)) u_prv (
		.clk(clk), .we(prv_we), .waddr(prv_wa), .wdata(prv_wd),
		.re(ren), .raddr(raddr), .rdata(prv_rd)
	);

	// A next link never written still holds its free chain value after reset.
	assign rst_nxt = (raddr_q == AW'(NODES - 1)) ? NIL : (LW'(raddr_q) + LW'(1));
	assign nxt_rd  = nvld_rd_q ? nxt_ram_rd : rst_nxt;

	always_comb begin
		ren    = 1'b0;
		raddr  = head_q[AW-1:0];
		val_we = 1'b0;
		val_wa = free_q[AW-1:0];
		val_wd = value_q;
		nxt_we = 1'b0;
		nxt_wa = free_q[AW-1:0];
		nxt_wd = s_ins_q;
		prv_we = 1'b0;
		prv_wa = free_q[AW-1:0];
		prv_wd = p_ins_q;
		case (ctl.op)
			OP_LOAD: begin
				ren   = 1'b1;
				raddr = head_q[AW-1:0];
			end
			OP_ADV, OP_SEL_SUCC: begin
				ren   = 1'b1;
				raddr = nxt_rd[AW-1:0];
			end
			OP_PUT_HEAD, OP_PUT_TAIL, OP_PUT_AFTER, OP_PUT_SORTED: begin
				ren   = 1'b1;
				raddr = free_q[AW-1:0];
			end
			OP_INS1: begin
				val_we = 1'b1;
				nxt_we = 1'b1;
				prv_we = 1'b1;
			end
			OP_INS2: begin
				nxt_we = !p_ins_q[AW];
				nxt_wa = p_ins_q[AW-1:0];
				nxt_wd = n_q;
				prv_we = !s_ins_q[AW];
				prv_wa = s_ins_q[AW-1:0];
				prv_wd = n_q;
			end
			OP_SEL_HEAD: begin
				ren   = 1'b1;
				raddr = head_q[AW-1:0];
			end
			OP_SEL_TAIL: begin
				ren   = 1'b1;
				raddr = tail_q[AW-1:0];
			end
			OP_SEL_CUR: begin
				ren   = 1'b1;
				raddr = p_q[AW-1:0];
			end
			OP_UNL1: begin
				nxt_we = !prv_rd[AW];
				nxt_wa = prv_rd[AW-1:0];
				nxt_wd = nxt_rd;
				prv_we = !nxt_rd[AW];
				prv_wa = nxt_rd[AW-1:0];
				prv_wd = prv_rd;
			end
			OP_UNL2: begin
				nxt_we = 1'b1;
				nxt_wa = n_q[AW-1:0];
				nxt_wd = free_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= NIL;
			tail_q <= NIL;
			free_q <= '0;
			nvld_q <= '0;
		end else begin
			if (nxt_we) begin
				nvld_q[nxt_wa] <= 1'b1;
			end
			case (ctl.op)
				OP_INS1: free_q <= nxt_rd;
				OP_INS2: begin
					if (p_ins_q[AW]) begin
						head_q <= n_q;
					end
					if (s_ins_q[AW]) begin
						tail_q <= n_q;
					end
				end
				OP_UNL1: begin
					if (prv_rd[AW]) begin
						head_q <= nxt_rd;
					end
					if (nxt_rd[AW]) begin
						tail_q <= prv_rd;
					end
				end
				OP_UNL2: free_q <= n_q;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ren) begin
			raddr_q   <= raddr;
			nvld_rd_q <= nvld_q[raddr];
		end
		case (ctl.op)
			OP_LOAD: begin
				value_q <= value;
				loc_q   <= location;
				p_q     <= head_q;
				last_q  <= NIL;
			end
			OP_ADV: begin
				last_q <= p_q;
				p_q    <= nxt_rd;
			end
			OP_PUT_HEAD: begin
				p_ins_q <= NIL;
				s_ins_q <= head_q;
			end
			OP_PUT_TAIL: begin
				p_ins_q <= tail_q;
				s_ins_q <= NIL;
			end
			OP_PUT_AFTER: begin
				p_ins_q <= p_q;
				s_ins_q <= nxt_rd;
			end
			OP_PUT_SORTED: begin
				p_ins_q <= last_q;
				s_ins_q <= p_q;
			end
			OP_INS1:     n_q <= free_q;
			OP_SEL_HEAD: n_q <= head_q;
			OP_SEL_TAIL: n_q <= tail_q;
			OP_SEL_SUCC: n_q <= nxt_rd;
			OP_SEL_CUR:  n_q <= p_q;
			default: begin
			end
		endcase
	end

	assign sts.full        = free_q[AW];
	assign sts.empty       = head_q[AW];
	assign sts.p_null      = p_q[AW];
	assign sts.hit_loc     = CW'(p_q) == CW'(loc_q);
	assign sts.hit_val     = val_rd == value_q;
	assign sts.less        = value_q < $signed(val_rd);
	assign sts.loc_bad     = CW'(loc_q) >= CW'(NODES);
	assign sts.loc_is_tail = CW'(tail_q) == CW'(loc_q);

	assign cur_idx  = 6'(p_q[AW-1:0]);
	assign node_idx = 6'(n_q[AW-1:0]);

endmodule
`default_nettype wire

// ===== sv/pdl_ctrl.sv =====
`default_nettype none
module pdl_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire logic [3:0]    cmd,
	input  wire logic          location_none,
	output logic               out_valid,
	input  wire logic          out_stall,
	output logic [2:0]         status,
	output logic [5:0]         node_index,
	output logic               index_valid,
	output pdl_pkg::ctl_t      ctl,
	input  wire pdl_pkg::sts_t sts,
	input  wire logic [5:0]    cur_idx,
	input  wire logic [5:0]    node_idx
);
	import pdl_pkg::*;

	state_t state_q, state_d;
	logic [3:0] cmd_q;
	logic       none_q;
	logic [2:0] res_st_q, res_st_d;
	logic [5:0] res_idx_q, res_idx_d;
	logic       res_iv_q, res_iv_d, res_set;
	logic       out_load;
	logic       out_valid_q, index_valid_q;
	logic [2:0] status_q;
	logic [5:0] node_index_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.op == OP_LOAD) begin
			cmd_q  <= cmd;
			none_q <= location_none;
		end
		if (res_set) begin
			res_st_q  <= res_st_d;
			res_idx_q <= res_idx_d;
			res_iv_q  <= res_iv_d;
		end
		if (out_load) begin
			status_q      <= res_st_q;
			node_index_q  <= res_iv_q ? res_idx_q : 6'd0;
			index_valid_q <= res_iv_q;
		end
	end

	always_comb begin
		state_d   = state_q;
		ctl.op    = OP_NOP;
		in_stall  = 1'b1;
		res_set   = 1'b0;
		res_st_d  = ST_OK;
		res_idx_d = node_idx;
		res_iv_d  = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					ctl.op  = OP_LOAD;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_DONE;
				res_set = 1'b1;
				case (cmd_q)
					CMD_INS_HEAD, CMD_INS_TAIL: begin
						if (sts.full) begin
							res_st_d = ST_OVERFLOW;
						end else begin
							res_set = 1'b0;
							ctl.op  = (cmd_q == CMD_INS_HEAD) ? OP_PUT_HEAD : OP_PUT_TAIL;
							state_d = S_INS1;
						end
					end
					CMD_INS_AFTER: begin
						if (sts.full) begin
							res_st_d = ST_OVERFLOW;
						end else if (none_q) begin
							res_set = 1'b0;
							ctl.op  = OP_PUT_HEAD;
							state_d = S_INS1;
						end else if (sts.loc_bad || sts.p_null) begin
							res_st_d = ST_BAD_LOC;
						end else if (sts.hit_loc) begin
							res_set = 1'b0;
							ctl.op  = OP_PUT_AFTER;
							state_d = S_INS1;
						end else begin
							res_set = 1'b0;
							ctl.op  = OP_ADV;
							state_d = S_EXEC;
						end
					end
					CMD_INS_SORTED: begin
						if (sts.full) begin
							res_st_d = ST_OVERFLOW;
						end else if (sts.p_null || sts.less) begin
							res_set = 1'b0;
							ctl.op  = OP_PUT_SORTED;
							state_d = S_INS1;
						end else begin
							res_set = 1'b0;
							ctl.op  = OP_ADV;
							state_d = S_EXEC;
						end
					end
					CMD_DEL_HEAD, CMD_DEL_TAIL: begin
						if (sts.empty) begin
							res_st_d = ST_UNDERFLOW;
						end else begin
							res_set = 1'b0;
							ctl.op  = (cmd_q == CMD_DEL_HEAD) ? OP_SEL_HEAD : OP_SEL_TAIL;
							state_d = S_UNL1;
						end
					end
					CMD_DEL_AFTER: begin
						if (sts.empty) begin
							res_st_d = ST_UNDERFLOW;
						end else if (none_q) begin
							res_set = 1'b0;
							ctl.op  = OP_SEL_HEAD;
							state_d = S_UNL1;
						end else if (sts.loc_bad || sts.loc_is_tail || sts.p_null) begin
							res_st_d = ST_BAD_LOC;
						end else if (sts.hit_loc) begin
							res_set = 1'b0;
							ctl.op  = OP_SEL_SUCC;
							state_d = S_UNL1;
						end else begin
							res_set = 1'b0;
							ctl.op  = OP_ADV;
							state_d = S_EXEC;
						end
					end
					CMD_DEL_VALUE: begin
						if (sts.empty) begin
							res_st_d = ST_UNDERFLOW;
						end else if (sts.p_null) begin
							res_st_d = ST_NOT_FOUND;
						end else if (sts.hit_val) begin
							res_set = 1'b0;
							ctl.op  = OP_SEL_CUR;
							state_d = S_UNL1;
						end else begin
							res_set = 1'b0;
							ctl.op  = OP_ADV;
							state_d = S_EXEC;
						end
					end
					CMD_SEARCH: begin
						if (sts.p_null) begin
							res_st_d = ST_NOT_FOUND;
						end else if (sts.hit_val) begin
							res_idx_d = cur_idx;
							res_iv_d  = 1'b1;
						end else begin
							res_set = 1'b0;
							ctl.op  = OP_ADV;
							state_d = S_EXEC;
						end
					end
					default: begin
					end
				endcase
			end
			S_INS1: begin
				ctl.op  = OP_INS1;
				state_d = S_INS2;
			end
			S_INS2: begin
				ctl.op   = OP_INS2;
				res_set  = 1'b1;
				res_iv_d = 1'b1;
				state_d  = S_DONE;
			end
			S_UNL1: begin
				ctl.op  = OP_UNL1;
				state_d = S_UNL2;
			end
			S_UNL2: begin
				ctl.op   = OP_UNL2;
				res_set  = 1'b1;
				res_iv_d = 1'b1;
				state_d  = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign node_index  = node_index_q;
	assign index_valid = index_valid_q;

endmodule
`default_nettype wire
